// ===== rtl/psdw_pkg.sv =====
package psdw_pkg;

	localparam int ENTRIES     = 16;
	localparam int WINDOW_BITS = 64;
	localparam int SRC_W       = 48;
	localparam int SEQ_W       = 16;
	localparam int LIFE_W      = 15;
	localparam int WIN_IDX_W   = $clog2(WINDOW_BITS);
	localparam int CNT_W       = $clog2(ENTRIES + 1);
	localparam int FREED_W     = 5;
	localparam int FREED_MAX   = 31;

	localparam logic [SEQ_W-1:0]  HALF_SPACE    = 16'd32768;
	localparam logic [LIFE_W-1:0] LIFETIME_INIT = 15'd30;

	typedef enum logic [1:0] {
		ACT_CHECK = 2'd0,
		ACT_TICK  = 2'd1,
		ACT_FLUSH = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		VERD_NEW  = 2'd0,
		VERD_LATE = 2'd1,
		VERD_DUP  = 2'd2,
		VERD_FULL = 2'd3
	} verdict_t;

	// command broadcast to every cell in the execute cycle
	typedef struct packed {
		logic              en;
		action_t           action;
		logic [SRC_W-1:0]  src;
		logic [SEQ_W-1:0]  seq;
		logic [LIFE_W-1:0] lifetime;
		logic              any_hit;
	} cmd_t;

	// priority data handed from cell to cell, lowest index first
	typedef struct packed {
		logic       hit;
		logic       free;
		logic [1:0] verdict;
	} chain_t;

endpackage

// ===== rtl/psdw_cell.sv =====
module psdw_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  psdw_pkg::cmd_t     cmd,
	input  psdw_pkg::chain_t   chain_in,
	output psdw_pkg::chain_t   chain_out,
	output logic               match,
	output logic               expire
);

	logic                               valid_q;
	logic [psdw_pkg::SRC_W-1:0]         src_q;
	logic [psdw_pkg::SEQ_W-1:0]         last_q;
	logic [psdw_pkg::WINDOW_BITS-1:0]   map_q;
	logic [psdw_pkg::LIFE_W-1:0]        life_q;

	logic                               sel_hit;
	logic                               alloc;
	logic                               is_check;
	logic [psdw_pkg::SEQ_W-1:0]         last_b;
	logic [psdw_pkg::WINDOW_BITS-1:0]   map_b;
	logic [psdw_pkg::SEQ_W-1:0]         d;
	logic [psdw_pkg::SEQ_W-1:0]         ds;
	logic                               is_new;
	logic                               is_late;
	logic [psdw_pkg::WINDOW_BITS-1:0]   map_new;
	logic [psdw_pkg::WINDOW_BITS-1:0]   map_late;
	logic [1:0]                         my_verdict;

	// key match and slot choice
	assign match    = valid_q && (src_q == cmd.src);
	assign is_check = cmd.action == psdw_pkg::ACT_CHECK;
	assign sel_hit  = match && !chain_in.hit;
	assign alloc    = !valid_q && !chain_in.free && !cmd.any_hit;

	// window classification on the selected entry
	always_comb begin
		last_b   = alloc ? (cmd.seq - psdw_pkg::SEQ_W'(1)) : last_q;
		map_b    = alloc ? '0 : map_q;
		d        = cmd.seq - last_b;
		ds       = last_b - cmd.seq;
		is_new   = (last_b < cmd.seq) || (ds > psdw_pkg::HALF_SPACE);
		map_new  = (d >= psdw_pkg::SEQ_W'(psdw_pkg::WINDOW_BITS)) ? '0 : (map_b << d);
		map_new[0] = 1'b1;
		is_late  = (ds < psdw_pkg::SEQ_W'(psdw_pkg::WINDOW_BITS))
			&& !map_b[ds[psdw_pkg::WIN_IDX_W-1:0]];
		map_late = map_b;
		map_late[ds[psdw_pkg::WIN_IDX_W-1:0]] = 1'b1;
		if (is_new) begin
			my_verdict = psdw_pkg::VERD_NEW;
		end else if (is_late) begin
			my_verdict = psdw_pkg::VERD_LATE;
		end else begin
			my_verdict = psdw_pkg::VERD_DUP;
		end
		if (!(cmd.en && is_check && (sel_hit || alloc))) begin
			my_verdict = psdw_pkg::VERD_NEW;
		end
	end

	assign expire = cmd.en && (cmd.action == psdw_pkg::ACT_TICK) && valid_q
		&& (life_q <= psdw_pkg::LIFE_W'(1));

	// pass priority state to the next cell
	assign chain_out.hit     = chain_in.hit | match;
	assign chain_out.free    = chain_in.free | !valid_q;
	assign chain_out.verdict = chain_in.verdict | my_verdict;

	// entry valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.en) begin
			unique case (cmd.action)
				psdw_pkg::ACT_CHECK: if (alloc) valid_q <= 1'b1;
				psdw_pkg::ACT_TICK:  if (expire) valid_q <= 1'b0;
				psdw_pkg::ACT_FLUSH: valid_q <= 1'b0;
				default: ;
			endcase
		end
	end

	// entry payload
	always_ff @(posedge clk) begin
		if (cmd.en) begin
			unique case (cmd.action)
				psdw_pkg::ACT_CHECK: begin
					if (sel_hit || alloc) begin
						src_q  <= cmd.src;
						life_q <= cmd.lifetime;
						if (is_new) begin
							map_q  <= map_new;
							last_q <= cmd.seq;
						end else begin
							last_q <= last_b;
							map_q  <= is_late ? map_late : map_b;
						end
					end
				end
				psdw_pkg::ACT_TICK: begin
					if (valid_q) life_q <= expire ? '0 : life_q - psdw_pkg::LIFE_W'(1);
				end
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/per_source_duplicate_window.sv =====
// channel | dir | signals                    | contents
// s       | in  | tvalid tready tdata tuser   | check, tick or flush command
// m       | out | tvalid tready tdata         | verdict and freed count
// cfg     | in  | cfg_we cfg_wdata            | entry lifetime
//
// an item passes an execute stage across the entry cell row, then a count stage
// for freed entries; the next beat is taken as the count stage moves on
// a finished result waits in the output register while the next item executes
// reset clears all entry valid flags at once and loads the lifetime with 30
// the key match and free-slot choice ripple through the cell row combinationally
module per_source_duplicate_window (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [14:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // source_address[47:0], sequence_req[63:48]
	input  logic [1:0]  s_tuser,   // action[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata    // verdict[1:0], freed_count[6:2], zero[7]
);

	logic [psdw_pkg::LIFE_W-1:0] lifetime_q;
	logic                        v_s1;
	psdw_pkg::action_t           action_s1;
	logic [psdw_pkg::SRC_W-1:0]  src_s1;
	logic [psdw_pkg::SEQ_W-1:0]  seq_s1;
	logic                        v_s2;
	logic [1:0]                  verdict_s2;
	logic [psdw_pkg::ENTRIES-1:0] expire_s2;
	logic                        out_valid_q;
	logic [7:0]                  out_data_q;

	psdw_pkg::cmd_t              cmd;
	psdw_pkg::chain_t            chain [psdw_pkg::ENTRIES+1];
	logic [psdw_pkg::ENTRIES-1:0] match;
	logic [psdw_pkg::ENTRIES-1:0] expire;
	logic                        move;
	logic [1:0]                  verdict;
	logic [psdw_pkg::CNT_W-1:0]  cnt;
	logic [psdw_pkg::FREED_W-1:0] freed;

	assign move     = v_s2 && (!out_valid_q || m_tready);
	assign s_tready = !v_s1 && (!v_s2 || move);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// lifetime register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lifetime_q <= psdw_pkg::LIFETIME_INIT;
		end else if (cfg_we) begin
			lifetime_q <= cfg_wdata;
		end
	end

	// command broadcast
	always_comb begin
		cmd.en       = v_s1;
		cmd.action   = action_s1;
		cmd.src      = src_s1;
		cmd.seq      = seq_s1;
		cmd.lifetime = lifetime_q;
		cmd.any_hit  = chain[psdw_pkg::ENTRIES].hit;
	end

	assign chain[0] = '{hit: 1'b0, free: 1'b0, verdict: 2'b00};

	// row of entry cells
	for (genvar i = 0; i < psdw_pkg::ENTRIES; i++) begin : g_cell
		psdw_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.chain_in  (chain[i]),
			.chain_out (chain[i+1]),
			.match     (match[i]),
			.expire    (expire[i])
		);
	end

	// table full when a check finds neither its source nor a free slot
	always_comb begin
		verdict = chain[psdw_pkg::ENTRIES].verdict;
		if ((action_s1 == psdw_pkg::ACT_CHECK) && !(|match)
			&& !chain[psdw_pkg::ENTRIES].free) begin
			verdict = psdw_pkg::VERD_FULL;
		end
	end

	// freed entry count, saturated
	always_comb begin
		cnt = psdw_pkg::CNT_W'($countones(expire_s2));
		if (32'(cnt) > psdw_pkg::FREED_MAX) begin
			freed = psdw_pkg::FREED_W'(psdw_pkg::FREED_MAX);
		end else begin
			freed = psdw_pkg::FREED_W'(cnt);
		end
	end

	// stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= s_tvalid && s_tready;
			if (v_s1) begin
				v_s2 <= 1'b1;
			end else if (move) begin
				v_s2 <= 1'b0;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			action_s1 <= psdw_pkg::action_t'(s_tuser);
			src_s1    <= s_tdata[47:0];
			seq_s1    <= s_tdata[63:48];
		end
		if (v_s1) begin
			verdict_s2 <= verdict;
			expire_s2  <= expire;
		end
		if (move) begin
			out_data_q <= {1'b0, freed, verdict_s2};
		end
	end

endmodule

// ===== rtl/psdw_checker.sv =====
module psdw_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata
);

	// a stalled result stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

	// one item at a time in the execute cycle
	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("beat taken during execute");

	// freed count comes only with a zero verdict
	a_freed_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[6:2] == 5'd0) || (m_tdata[1:0] == 2'd0))
		else $error("freed count with nonzero verdict");

endmodule

bind per_source_duplicate_window psdw_checker u_psdw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
